// ----- hw/rtl/ltps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ltps_pkg;
	localparam int MAX_CANDIDATES = 8;
	localparam int ROW_BITS       = 12;
	localparam int MAX_COLUMNS    = 4096;
	localparam int EMPTY_COST     = 5000;
	localparam int MIN_GAP        = 2;

	localparam int CNT_IN_BITS = 4;
	localparam int COL_BITS    = 13;
	localparam int CNT_BITS    = $clog2(MAX_CANDIDATES + 1);
	localparam int IDX_BITS    = $clog2(MAX_CANDIDATES);
	localparam int POS_BITS    = $clog2(MAX_COLUMNS + 1);
	localparam int NEAR_BITS   = (ROW_BITS > $clog2(EMPTY_COST + 1)) ?
		ROW_BITS : $clog2(EMPTY_COST + 1);
	localparam int COST_BITS   = NEAR_BITS + 1;
	localparam int SCORE_BITS  = NEAR_BITS + 2;

	localparam int IN_RAW_BITS   = CNT_IN_BITS + MAX_CANDIDATES * ROW_BITS;
	localparam int IN_DATA_BITS  = ((IN_RAW_BITS + 7) / 8) * 8;
	localparam int OUT_RAW_BITS  = COL_BITS + ROW_BITS + 1;
	localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

	typedef logic signed [ROW_BITS-1:0] row_t;
	typedef row_t rows_t [MAX_CANDIDATES];
	typedef logic [COST_BITS-1:0] cost_t;
	typedef cost_t costs_t [MAX_CANDIDATES];

	typedef struct packed {
		logic                  found;
		logic [SCORE_BITS-1:0] score;
		logic [ROW_BITS-1:0]   span;
		logic [IDX_BITS-1:0]   k;
	} pair_t;
	typedef pair_t pairs_t [MAX_CANDIDATES];

	typedef struct packed {
		logic                found;
		logic [ROW_BITS-1:0] span;
		logic [IDX_BITS-1:0] e;
		logic [IDX_BITS-1:0] k;
	} pick_t;

	function automatic logic [ROW_BITS-1:0] absdiff(input row_t a, input row_t b);
		logic signed [ROW_BITS:0] d;
		d = $signed({a[ROW_BITS-1], a}) - $signed({b[ROW_BITS-1], b});
		return d[ROW_BITS] ? ROW_BITS'(-d) : d[ROW_BITS-1:0];
	endfunction

	function automatic logic [NEAR_BITS-1:0] nearest(input row_t p, input rows_t rows,
		input logic [CNT_BITS-1:0] n);
		logic [NEAR_BITS-1:0] best;
		logic [NEAR_BITS-1:0] d;
		best = NEAR_BITS'(EMPTY_COST);
		for (int i = 0; i < MAX_CANDIDATES; i++) begin
			d = NEAR_BITS'(absdiff(rows[i], p));
			if (i < int'(n) && d < best)
				best = d;
		end
		return best;
	endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/ltps_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ltps_lane (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire ltps_pkg::row_t              row,
	input  wire ltps_pkg::rows_t             prev_rows,
	input  wire logic [ltps_pkg::CNT_BITS-1:0] prev_cnt,
	input  wire logic                        has_prev,
	input  wire ltps_pkg::rows_t             next_rows,
	input  wire logic [ltps_pkg::CNT_BITS-1:0] next_cnt,
	input  wire logic                        has_next,
	output ltps_pkg::cost_t                  cost_s1
);
	import ltps_pkg::*;

	logic [NEAR_BITS-1:0] near_prev, near_next;
	cost_t cost;

	always_comb begin
		near_prev = has_prev ? nearest(row, prev_rows, prev_cnt) : '0;
		near_next = has_next ? nearest(row, next_rows, next_cnt) : '0;
		cost = COST_BITS'(near_prev) + COST_BITS'(near_next);
	end

	always_ff @(posedge clk) begin
		if (en)
			cost_s1 <= cost;
	end
endmodule
`default_nettype wire

// ----- hw/rtl/ltps_pair.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ltps_pair (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [ltps_pkg::IDX_BITS-1:0] e,
	input  wire ltps_pkg::rows_t               rows,
	input  wire ltps_pkg::costs_t              costs,
	input  wire logic [ltps_pkg::CNT_BITS-1:0] n,
	output ltps_pkg::pair_t                    pair_s2
);
	import ltps_pkg::*;

	pair_t best;
	logic [SCORE_BITS-1:0] score;
	logic [ROW_BITS-1:0] span;
	logic ok;

	// Best partner k above this lane's row; the earliest k wins a full tie.
	always_comb begin
		best = '0;
		for (int k = 0; k < MAX_CANDIDATES; k++) begin
			span  = absdiff(rows[e], rows[k]);
			score = SCORE_BITS'(costs[e]) + SCORE_BITS'(costs[k]);
			ok    = (k > int'(e)) && (k < int'(n)) && (int'(span) >= MIN_GAP);
			if (ok && (!best.found || score < best.score ||
				(score == best.score && span < best.span))) begin
				best.found = 1'b1;
				best.score = score;
				best.span  = span;
				best.k     = IDX_BITS'(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			pair_s2 <= best;
	end
endmodule
`default_nettype wire

// ----- hw/rtl/ltps_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ltps_merge (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire ltps_pkg::pairs_t pairs,
	output ltps_pkg::pick_t       pick_s3
);
	import ltps_pkg::*;

	pick_t best;
	logic [SCORE_BITS-1:0] best_score;

	always_comb begin
		best = '0;
		best_score = '0;
		for (int e = 0; e < MAX_CANDIDATES; e++) begin
			if (pairs[e].found && (!best.found || pairs[e].score < best_score ||
				(pairs[e].score == best_score && pairs[e].span < best.span))) begin
				best.found = 1'b1;
				best.span  = pairs[e].span;
				best.e     = IDX_BITS'(e);
				best.k     = pairs[e].k;
				best_score = pairs[e].score;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			pick_s3 <= best;
	end
endmodule
`default_nettype wire

// ----- hw/rtl/line_thickness_pair_select_unit.sv -----
// Flow: a column that completes its predecessor sends that result through the COST,
// PAIR, MERGE and EMIT states; a final column then sends its own result through them,
// or does so alone when it has no predecessor. Throughput: a column that only becomes
// pending is taken in IDLE, which stays ready; one that completes its predecessor or
// stands alone as a final column holds IDLE off for one pass, a final column with a
// predecessor for two; set by the cost, pair and merge stages, plus any output wait.
// Reset: arst_n clears the line state, the origin register and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none
module line_thickness_pair_select_unit (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [ltps_pkg::COL_BITS-1:0]          cfg_data,
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// candidate_count, row_0 .. row_7, zero pad
	input  wire logic [ltps_pkg::IN_DATA_BITS-1:0]      s_tdata,
	input  wire logic                                   s_tlast,
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// column_number, thickness, thickness_valid, zero pad
	output logic [ltps_pkg::OUT_DATA_BITS-1:0]          m_tdata,
	output logic                                        m_tlast
);
	import ltps_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_COST  = 3'd1;
	localparam logic [2:0] ST_PAIR  = 3'd2;
	localparam logic [2:0] ST_MERGE = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	localparam logic JOB_PEND = 1'b0;
	localparam logic JOB_LAST = 1'b1;

	logic [2:0] state_q;
	logic job_q, last_q, pend_q;
	logic signed [COL_BITS-1:0] origin_q;
	rows_t prev_rows_q, pend_rows_q, cur_rows_q, in_rows, subj_rows, red_rows;
	logic [CNT_BITS-1:0] prev_cnt_q, pend_cnt_q, cur_cnt_q, in_cnt, subj_cnt, red_cnt;
	logic [POS_BITS-1:0] pos_q, cur_pos, emit_pos;
	logic has_prev, out_free, emit;
	costs_t costs_s1;
	pairs_t pairs_s2;
	pick_t pick_s3;
	logic [ROW_BITS-1:0] thick;
	logic out_valid_q, out_last_q;
	logic [OUT_RAW_BITS-1:0] out_q;

	always_comb begin
		for (int i = 0; i < MAX_CANDIDATES; i++)
			in_rows[i] = s_tdata[CNT_IN_BITS + i*ROW_BITS +: ROW_BITS];
		in_cnt = (int'(s_tdata[CNT_IN_BITS-1:0]) > MAX_CANDIDATES) ?
			CNT_BITS'(MAX_CANDIDATES) : CNT_BITS'(s_tdata[CNT_IN_BITS-1:0]);
		cur_pos = (int'(pos_q) < MAX_COLUMNS) ? pos_q + 1'b1 : pos_q;
		subj_rows = (job_q == JOB_LAST) ? cur_rows_q : pend_rows_q;
		subj_cnt  = (job_q == JOB_LAST) ? cur_cnt_q : pend_cnt_q;
		emit_pos  = (job_q == JOB_LAST) ? cur_pos : pos_q;
		has_prev  = int'(emit_pos) > 1;
	end

	// One lane per candidate row; every lane also searches partners for its row.
	for (genvar g = 0; g < MAX_CANDIDATES; g++) begin : g_lane
		ltps_lane u_lane (
			.clk(clk), .en(state_q == ST_COST), .row(subj_rows[g]),
			.prev_rows(prev_rows_q), .prev_cnt(prev_cnt_q), .has_prev(has_prev),
			.next_rows(cur_rows_q), .next_cnt(cur_cnt_q), .has_next(job_q == JOB_PEND),
			.cost_s1(costs_s1[g])
		);
		ltps_pair u_pair (
			.clk(clk), .en(state_q == ST_PAIR), .e(IDX_BITS'(g)), .rows(subj_rows),
			.costs(costs_s1), .n(subj_cnt), .pair_s2(pairs_s2[g])
		);
	end

	ltps_merge u_merge (
		.clk(clk), .en(state_q == ST_MERGE), .pairs(pairs_s2), .pick_s3(pick_s3)
	);

	// With exactly two rows that sit too close together the column empties.
	always_comb begin
		red_rows = subj_rows;
		red_cnt  = subj_cnt;
		thick    = '0;
		if (pick_s3.found) begin
			red_rows[0] = subj_rows[pick_s3.e];
			red_rows[1] = subj_rows[pick_s3.k];
			red_cnt     = CNT_BITS'(2);
			thick       = pick_s3.span;
		end else if (int'(subj_cnt) == 2) begin
			red_cnt = '0;
		end
	end

	assign out_free = !out_valid_q || m_tready;
	assign emit     = (state_q == ST_EMIT) && out_free;
	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			job_q       <= JOB_PEND;
			last_q      <= 1'b0;
			pend_q      <= 1'b0;
			origin_q    <= '0;
			prev_cnt_q  <= '0;
			pend_cnt_q  <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				origin_q <= cfg_data;
			if (emit)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						last_q <= s_tlast;
						if (pend_q) begin
							job_q   <= JOB_PEND;
							state_q <= ST_COST;
						end else if (s_tlast) begin
							job_q   <= JOB_LAST;
							state_q <= ST_COST;
						end else begin
							pend_cnt_q <= in_cnt;
							pend_q     <= 1'b1;
							pos_q      <= cur_pos;
						end
					end
				end
				ST_COST:  state_q <= ST_PAIR;
				ST_PAIR:  state_q <= ST_MERGE;
				ST_MERGE: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_free) begin
						if (job_q == JOB_PEND) begin
							prev_cnt_q <= red_cnt;
							if (last_q) begin
								job_q   <= JOB_LAST;
								state_q <= ST_COST;
							end else begin
								pend_cnt_q <= cur_cnt_q;
								pos_q      <= cur_pos;
								state_q    <= ST_IDLE;
							end
						end else begin
							prev_cnt_q <= '0;
							pend_cnt_q <= '0;
							pend_q     <= 1'b0;
							pos_q      <= '0;
							state_q    <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cur_rows_q <= in_rows;
			cur_cnt_q  <= in_cnt;
			if (!pend_q && !s_tlast)
				pend_rows_q <= in_rows;
		end
		if (emit && job_q == JOB_PEND) begin
			prev_rows_q <= red_rows;
			if (!last_q)
				pend_rows_q <= cur_rows_q;
		end
		if (emit) begin
			out_q      <= {thick != '0, thick,
				COL_BITS'(origin_q + $signed({1'b0, emit_pos}))};
			out_last_q <= (job_q == JOB_LAST);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_BITS'(out_q);
	assign m_tlast  = out_last_q;

	a_prev_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		int'(prev_cnt_q) <= MAX_CANDIDATES)
		else $error("previous column count out of range");
	a_thick_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tdata[COL_BITS+ROW_BITS] ||
		int'(m_tdata[COL_BITS +: ROW_BITS]) >= MIN_GAP))
		else $error("valid thickness below minimum gap");
	a_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && job_q == JOB_LAST) |=> (pos_q == '0 && !pend_q && state_q == ST_IDLE))
		else $error("line state not cleared after final column");
	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		int'(pos_q) <= MAX_COLUMNS)
		else $error("column position beyond limit");
endmodule
`default_nettype wire
